@@ src/cse_pkg.sv @@
// Types, constants and the byte escape function for the C string escape encoder.
package cse_pkg;

   localparam int unsigned SegChars = 4;
   localparam int unsigned SegCount = 4;
   localparam int unsigned MaxChars = 12;

   localparam logic [7:0] WidthReset = 8'd80;
   localparam logic [7:0] MinWidth   = 8'd16;
   localparam logic [8:0] WrapRoom   = 9'd6;

   localparam logic [7:0] ChQuote     = 8'h22;
   localparam logic [7:0] ChBackslash = 8'h5c;
   localparam logic [7:0] ChNewline   = 8'h0a;
   localparam logic [7:0] ChSpace     = 8'h20;
   localparam logic [7:0] ChBang      = 8'h21;
   localparam logic [7:0] ChHash      = 8'h23;
   localparam logic [7:0] ChRBracket  = 8'h5d;
   localparam logic [7:0] ChZero      = 8'h30;
   localparam logic [7:0] ChSeven     = 8'h37;
   localparam logic [7:0] CtlFirst    = 8'h07;
   localparam logic [7:0] CtlEnd      = 8'h0e;
   localparam logic [7:0] ChDel       = 8'h7f;

   // One run of up to four output characters; chars[0] goes out first.
   typedef struct packed {
      logic [SegChars-1:0][7:0] chars;
      logic [2:0]               len;
   } seg_type;

   localparam seg_type SegEmpty = '{chars: '0, len: 3'd0};
   localparam seg_type SegQuote = '{chars: {24'h000000, ChQuote}, len: 3'd1};
   localparam seg_type SegWrap  = '{chars: {8'h00, ChQuote, ChNewline, ChQuote}, len: 3'd3};

   function automatic logic [7:0] ctl_letter(input logic [2:0] idx);
      logic [7:0] l;
      case (idx)
         3'd0:    l = 8'h61; // a
         3'd1:    l = 8'h62; // b
         3'd2:    l = 8'h74; // t
         3'd3:    l = 8'h6e; // n
         3'd4:    l = 8'h76; // v
         3'd5:    l = 8'h66; // f
         3'd6:    l = 8'h72; // r
         default: l = 8'h72;
      endcase
      return l;
   endfunction

   // Escape byte c; nxt is the byte that follows it (zero at end of stream).
   function automatic seg_type escape_seg(input logic [7:0] c, input logic [7:0] nxt);
      seg_type    s;
      logic [1:0] d0;
      logic [2:0] d1;
      logic [2:0] d2;
      logic [7:0] idx;
      d0  = c[7:6];
      d1  = c[5:3];
      d2  = c[2:0];
      idx = c - CtlFirst;
      s   = SegEmpty;
      if (c >= CtlFirst && c < CtlEnd) begin
         s.chars[0] = ChBackslash;
         s.chars[1] = ctl_letter(idx[2:0]);
         s.len      = 3'd2;
      end else if (c == ChSpace || c == ChBang) begin
         s.chars[0] = c;
         s.len      = 3'd1;
      end else if (c == ChQuote || c == ChBackslash) begin
         s.chars[0] = ChBackslash;
         s.chars[1] = c;
         s.len      = 3'd2;
      end else if ((c >= ChHash && c < ChBackslash) || (c >= ChRBracket && c < ChDel)) begin
         s.chars[0] = c;
         s.len      = 3'd1;
      end else begin
         s.chars[0] = ChBackslash;
         if (d0 != 2'd0 || (nxt >= ChZero && nxt <= ChSeven)) begin
            s.chars[1] = {6'b001100, d0};
            s.chars[2] = {5'b00110, d1};
            s.chars[3] = {5'b00110, d2};
            s.len      = 3'd4;
         end else if (d1 != 3'd0) begin
            s.chars[1] = {5'b00110, d1};
            s.chars[2] = {5'b00110, d2};
            s.len      = 3'd3;
         end else begin
            s.chars[1] = {5'b00110, d2};
            s.len      = 3'd2;
         end
      end
      return s;
   endfunction

endpackage

@@ src/c_string_escape_encoder.sv @@
// The first character of an item is offered in the cycle after its transfer.
// Throughput: one output character per cycle while rsp_tready is high, 1 to 12 per item;
// the drain of the four-run character buffer sets the item rate, and the next
// item is taken in the cycle its predecessor's last character transfers.
// Reset (synchronous, active high) empties the buffer, clears the held byte and
// line position, and sets the line width to 80.
module c_string_escape_encoder
   import cse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,  // line_width
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] data_byte
   input  logic       req_tlast,    // end_of_data
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] out_char
   output logic       rsp_tlast     // last_of_item
);

   logic [7:0] width_ff, width_in;
   logic [7:0] held_ff, held_in;
   logic       have_held_ff, have_held_in;
   logic [7:0] line_pos_ff, line_pos_in;
   logic [3:0] count_ff, count_in;
   seg_type    seg_ff [SegCount];
   seg_type    seg_in [SegCount];

   logic       req_xfer, rsp_xfer;
   logic [1:0] head;
   seg_type    enc_held, enc_last, new_seg [SegCount];
   logic [7:0] eff_width, pos_after, pos_mid;
   logic       do_wrap;

   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = count_ff != 4'd0;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign req_tready = (count_ff == 4'd0) || (count_ff == 4'd1 && rsp_tready);
   assign rsp_tlast  = count_ff == 4'd1;

   // first run still holding characters
   always_comb begin
      if (seg_ff[0].len != 3'd0) begin
         head = 2'd0;
      end else if (seg_ff[1].len != 3'd0) begin
         head = 2'd1;
      end else if (seg_ff[2].len != 3'd0) begin
         head = 2'd2;
      end else begin
         head = 2'd3;
      end
   end

   assign rsp_tdata = seg_ff[head].chars[0];

   always_comb begin
      eff_width = (width_ff < MinWidth) ? MinWidth : width_ff;
      enc_held  = escape_seg(held_ff, req_tdata);
      enc_last  = escape_seg(req_tdata, 8'h00);
      pos_after = line_pos_ff + {5'd0, enc_held.len};
      do_wrap   = ({1'b0, pos_after} + WrapRoom) >= {1'b0, eff_width};
      new_seg[1] = SegEmpty;
      if (have_held_ff) begin
         new_seg[0] = enc_held;
         if (do_wrap) begin
            new_seg[1] = SegWrap;
            pos_mid    = 8'd1;
         end else begin
            pos_mid    = pos_after;
         end
      end else if (line_pos_ff == 8'd0) begin
         new_seg[0] = SegQuote;
         pos_mid    = 8'd1;
      end else begin
         new_seg[0] = SegEmpty;
         pos_mid    = line_pos_ff;
      end
      if (req_tlast) begin
         new_seg[2] = enc_last;
         new_seg[3] = SegQuote;
      end else begin
         new_seg[2] = SegEmpty;
         new_seg[3] = SegEmpty;
      end
   end

   always_comb begin
      width_in     = csr_wr_en ? csr_wr_data : width_ff;
      held_in      = held_ff;
      have_held_in = have_held_ff;
      line_pos_in  = line_pos_ff;
      count_in     = count_ff;
      for (int i = 0; i < SegCount; i++) begin
         seg_in[i] = seg_ff[i];
      end
      if (req_xfer) begin
         for (int i = 0; i < SegCount; i++) begin
            seg_in[i] = new_seg[i];
         end
         count_in = {1'b0, new_seg[0].len} + {1'b0, new_seg[1].len}
                  + {1'b0, new_seg[2].len} + {1'b0, new_seg[3].len};
         if (req_tlast) begin
            held_in      = 8'h00;
            have_held_in = 1'b0;
            line_pos_in  = 8'd0;
         end else begin
            held_in      = req_tdata;
            have_held_in = 1'b1;
            line_pos_in  = pos_mid;
         end
      end else if (rsp_xfer) begin
         seg_in[head].chars = {8'h00, seg_ff[head].chars[SegChars-1:1]};
         seg_in[head].len   = seg_ff[head].len - 3'd1;
         count_in           = count_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WidthReset;
         held_ff      <= 8'h00;
         have_held_ff <= 1'b0;
         line_pos_ff  <= 8'd0;
         count_ff     <= 4'd0;
         for (int i = 0; i < SegCount; i++) begin
            seg_ff[i] <= SegEmpty;
         end
      end else begin
         width_ff     <= width_in;
         held_ff      <= held_in;
         have_held_ff <= have_held_in;
         line_pos_ff  <= line_pos_in;
         count_ff     <= count_in;
         for (int i = 0; i < SegCount; i++) begin
            seg_ff[i] <= seg_in[i];
         end
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 4'(MaxChars))
      else $error("character count exceeds buffer");

   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      count_ff == ({1'b0, seg_ff[0].len} + {1'b0, seg_ff[1].len}
                 + {1'b0, seg_ff[2].len} + {1'b0, seg_ff[3].len}))
      else $error("character count out of step with run lengths");

   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      !have_held_ff |-> line_pos_ff == 8'd0)
      else $error("line open with no held byte");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tlast |=> !have_held_ff && line_pos_ff == 8'd0)
      else $error("stream end did not clear state");

endmodule
